FILE: rtl/core/hpq_pkg.sv
// ----------------------------------------------------------------------------
// Heap priority queue package
// Sizes, shared types and helper functions for the level-organized binary
// heap: one cell and one store per tree level.
// ----------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

  localparam int DEPTH  = 256;
  localparam int KEY_W  = 32;

  localparam int LEVELS = $clog2(DEPTH + 1);
  localparam int IDX_W  = LEVELS - 1;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W  = LEVELS;
  localparam int NODE_W = LEVELS + 1;

  localparam int LAST_SLOTS = DEPTH - (2 ** (LEVELS - 1)) + 1;
  localparam int LAST_AW    = (LAST_SLOTS > 1) ? $clog2(LAST_SLOTS) : 1;

  localparam int IO_KEY_W   = 32;
  localparam int TOTAL_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 * IO_KEY_W + TOTAL_W + STATUS_W);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic             valid;
    logic             down;
    logic             phase;
    logic [IDX_W-1:0] pos;
    key_t             key;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] pos;
  } rd_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    key_t             wdata;
    logic             rea;
    logic [IDX_W-1:0] addra;
    logic             reb;
    logic [IDX_W-1:0] addrb;
  } ram_req_t;

  typedef struct packed {
    logic             rd_path;
    logic             rd_last;
    logic [LVL_W-1:0] tgt_lvl;
    logic [CNT_W-1:0] tgt_node1;
    logic [CNT_W-1:0] bound;
  } cell_ctl_t;

  typedef struct packed {
    logic done;
    logic root_we;
    key_t root_key;
  } sift_stat_t;

  function automatic logic ranks_before(key_t a, key_t b, logic mode);
    return mode ? (a < b) : (a > b);
  endfunction

  // Tree level of a node, given the node index plus one.
  function automatic logic [LVL_W-1:0] node_level(logic [CNT_W-1:0] n1);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n1[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hpq_ram.sv
// ----------------------------------------------------------------------------
// Heap level store
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_ram
  import hpq_pkg::*;
#(
  parameter int ADDR_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  key_t              wdata,
  input  logic              rea,
  input  logic [ADDR_W-1:0] addra,
  output key_t              rda,
  input  logic              reb,
  input  logic [ADDR_W-1:0] addrb,
  output key_t              rdb
);

  key_t mem [2 ** ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rea) begin
      rda <= mem[addra];
    end
    if (reb) begin
      rdb <= mem[addrb];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hpq_cell.sv
// ----------------------------------------------------------------------------
// Heap level cell
// Owns one tree level. Handles the sift token while it sits on this level:
// one compare step toward the root on insert, a child read and a compare
// step toward the leaves on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_cell
  import hpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [LVL_W-1:0] level,
  input  logic             mode,
  input  cell_ctl_t        ctl,
  input  tok_t             tok_in,
  input  key_t             par_a,
  input  rd_req_t          par_req,
  input  key_t             kid_a,
  input  key_t             kid_b,
  output ram_req_t         ram,
  output rd_req_t          kid_req,
  output tok_t             pass_up,
  output tok_t             pass_dn,
  output logic             done
);

  tok_t              tok;
  tok_t              tok_next;
  logic [IDX_W-1:0]  path_idx;
  logic [IDX_W-1:0]  path_addr;
  logic [LVL_W-1:0]  shamt;
  logic [CNT_W-1:0]  path_sel;
  logic [IDX_W-1:0]  lvl_mask;
  logic              path_hit;
  logic              last_hit;
  logic [IDX_W-1:0]  lpos;
  logic [NODE_W-1:0] lnode;
  logic [NODE_W-1:0] rnode;
  logic              l_ok;
  logic              r_ok;
  logic              go_up;
  logic              take_l;
  logic              take_r;

  // Slot of this level on the root path of the target node.
  assign shamt     = ctl.tgt_lvl - level;
  assign path_sel  = ctl.tgt_node1 >> shamt;
  assign lvl_mask  = IDX_W'((NODE_W'(1) << level) - NODE_W'(1));
  assign path_addr = IDX_W'(path_sel) & lvl_mask;
  assign path_hit  = ctl.rd_path && (level <= ctl.tgt_lvl);
  assign last_hit  = ctl.rd_last && (level == ctl.tgt_lvl);

  assign lpos  = IDX_W'({tok.pos, 1'b0});
  assign lnode = (NODE_W'(1) << ({1'b0, level} + (LVL_W + 1)'(1))) - NODE_W'(1)
                 + NODE_W'(lpos);
  assign rnode = lnode + NODE_W'(1);
  assign l_ok  = lnode < NODE_W'(ctl.bound);
  assign r_ok  = rnode < NODE_W'(ctl.bound);

  always_comb begin
    ram      = '0;
    kid_req  = '0;
    pass_up  = '0;
    pass_dn  = '0;
    done     = 1'b0;
    go_up    = 1'b0;
    take_l   = 1'b0;
    take_r   = 1'b0;
    tok_next = tok;

    if (path_hit || last_hit) begin
      ram.rea   = 1'b1;
      ram.addra = path_addr;
    end else if (par_req.en) begin
      ram.rea   = 1'b1;
      ram.addra = IDX_W'({par_req.pos, 1'b0});
      ram.reb   = 1'b1;
      ram.addrb = IDX_W'({par_req.pos, 1'b1});
    end

    if (tok.valid) begin
      if (!tok.down) begin
        go_up          = (level != '0) && ranks_before(tok.key, par_a, mode);
        ram.we         = 1'b1;
        ram.waddr      = path_idx;
        ram.wdata      = go_up ? par_a : tok.key;
        pass_up        = tok;
        pass_up.valid  = go_up;
        done           = !go_up;
        tok_next.valid = 1'b0;
      end else if (!tok.phase) begin
        kid_req.en     = 1'b1;
        kid_req.pos    = tok.pos;
        tok_next.phase = 1'b1;
      end else begin
        take_l = l_ok && ranks_before(kid_a, tok.key, mode);
        take_r = r_ok && (take_l ? ranks_before(kid_b, kid_a, mode)
                                 : ranks_before(kid_b, tok.key, mode));
        ram.we         = 1'b1;
        ram.waddr      = tok.pos;
        ram.wdata      = take_r ? kid_b : (take_l ? kid_a : tok.key);
        pass_dn.valid  = take_l || take_r;
        pass_dn.down   = 1'b1;
        pass_dn.phase  = 1'b0;
        pass_dn.pos    = IDX_W'({tok.pos, take_r});
        pass_dn.key    = tok.key;
        done           = !(take_l || take_r);
        tok_next.valid = 1'b0;
      end
    end

    if (tok_in.valid) begin
      tok_next = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (path_hit) begin
      path_idx <= path_addr;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hpq_ctrl.sv
// ----------------------------------------------------------------------------
// Heap queue controller
// Takes items, keeps the entry count, the root copy and the order mode,
// starts the sift token in the cell row and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_ctrl
  import hpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_write,
  input  logic                  cfg_data,
  output logic                  mode,
  output cell_ctl_t             ctl,
  output tok_t                  launch,
  output logic [LVL_W-1:0]      launch_lvl,
  input  sift_stat_t            stat,
  input  key_t                  lvl_rd [LEVELS]
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INS_RD = 6'b000010,
    S_REM_RD = 6'b000100,
    S_REM_GO = 6'b001000,
    S_SIFT   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  key_t                 top_key;
  key_t                 removed;
  logic [STATUS_W-1:0]  status;
  key_t                 ins_key;
  logic [LVL_W-1:0]     tgt_lvl;
  logic [CNT_W-1:0]     tgt_node1;
  key_t                 out_removed;
  key_t                 out_top;
  logic [TOTAL_W-1:0]   out_total;
  logic [STATUS_W-1:0]  out_status;
  logic                 accept;
  logic                 in_op;
  key_t                 in_key;
  logic                 out_load;
  logic [CNT_W-1:0]     count_inc;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_op     = s_tuser[0];
  assign in_key    = key_t'(signed'(s_tdata[IO_KEY_W-1:0]));
  assign out_load  = (state == S_FINISH) && (!m_tvalid || m_tready);
  assign count_inc = count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= 1'b0;
      count    <= '0;
      top_key  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_data;
      end
      if (stat.root_we) begin
        top_key <= stat.root_key;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_op == OP_INSERT) begin
              if (count == CNT_W'(DEPTH)) begin
                state <= S_FINISH;
              end else begin
                count <= count_inc;
                state <= S_INS_RD;
              end
            end else begin
              if (count == '0) begin
                state <= S_FINISH;
              end else begin
                count <= count - CNT_W'(1);
                if (count == CNT_W'(1)) begin
                  top_key <= '0;
                  state   <= S_FINISH;
                end else begin
                  state <= S_REM_RD;
                end
              end
            end
          end
        end
        S_INS_RD: state <= S_SIFT;
        S_REM_RD: state <= S_REM_GO;
        S_REM_GO: state <= S_SIFT;
        S_SIFT: begin
          if (stat.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ins_key <= in_key;
      if (in_op == OP_INSERT) begin
        tgt_node1 <= count_inc;
        tgt_lvl   <= node_level(count_inc);
        removed   <= '0;
        status    <= (count == CNT_W'(DEPTH)) ? ST_FULL : ST_OK;
      end else begin
        tgt_node1 <= count;
        tgt_lvl   <= node_level(count);
        if (count == '0) begin
          removed <= '0;
          status  <= ST_EMPTY;
        end else begin
          removed <= top_key;
          status  <= ST_OK;
        end
      end
    end
    if (out_load) begin
      out_removed <= removed;
      out_top     <= top_key;
      out_total   <= TOTAL_W'(count);
      out_status  <= status;
    end
  end

  always_comb begin
    ctl           = '0;
    ctl.rd_path   = (state == S_INS_RD);
    ctl.rd_last   = (state == S_REM_RD);
    ctl.tgt_lvl   = tgt_lvl;
    ctl.tgt_node1 = tgt_node1;
    ctl.bound     = count;

    launch     = '0;
    launch_lvl = '0;
    if (state == S_INS_RD) begin
      launch.valid = 1'b1;
      launch.key   = ins_key;
      launch_lvl   = tgt_lvl;
    end else if (state == S_REM_GO) begin
      launch.valid = 1'b1;
      launch.down  = 1'b1;
      launch.key   = lvl_rd[tgt_lvl];
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_status, out_total,
                    IO_KEY_W'(out_top), IO_KEY_W'(out_removed)};

endmodule

`default_nettype wire

FILE: rtl/core/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Signed-key heap kept as a row of level cells, one store per tree level.
//
// Input channel s_*: one item is an insert (s_tuser[0] = 0) of the key in
// s_tdata, or a remove of the top entry (s_tuser[0] = 1). Output channel m_*
// returns one item per input item: removed key, top key, entry count and a
// status code. The single register (cfg_write, cfg_data) selects max-heap (0)
// or min-heap (1). The user must write it only while the queue is idle; the
// block does not enforce this. One item is worked on at a time. An insert
// climbs one level per cycle. A remove descends one level at a time, each
// level needing a child read and a compare. Removes on an empty heap, inserts
// on a full heap and removes of the last entry finish without a sift.
// A finished result waits in the output register; while the receiver stalls
// it holds there and the next item is taken but not finished.
// Reset empties the heap and selects max-heap order; the stores need no
// clearing, since only slots below the entry count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue
  import hpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key
  input  logic [IN_USER_W-1:0]  s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // removed_key, top_key, entry_total, status
  input  logic                  cfg_write,
  input  logic                  cfg_data
);

  logic             mode;
  cell_ctl_t        ctl;
  tok_t             launch;
  logic [LVL_W-1:0] launch_lvl;
  sift_stat_t       stat;

  tok_t             tok_in  [LEVELS];
  tok_t             pass_up [LEVELS];
  tok_t             pass_dn [LEVELS];
  ram_req_t         ram_q   [LEVELS];
  rd_req_t          kid_req [LEVELS];
  key_t             rd_a    [LEVELS];
  key_t             rd_b    [LEVELS];
  logic [LEVELS-1:0] done_v;

  hpq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .ctl        (ctl),
    .launch     (launch),
    .launch_lvl (launch_lvl),
    .stat       (stat),
    .lvl_rd     (rd_a)
  );

  assign stat.done     = |done_v;
  assign stat.root_we  = ram_q[0].we;
  assign stat.root_key = ram_q[0].wdata;

  for (genvar i = 0; i < LEVELS; i++) begin : g_lvl
    localparam int LW = (i == LEVELS - 1) ? LAST_AW : ((i > 0) ? i : 1);

    key_t    par_a;
    rd_req_t par_req;
    key_t    kid_a;
    key_t    kid_b;
    tok_t    from_up;
    tok_t    from_dn;

    if (i == 0) begin : g_root
      assign par_a   = '0;
      assign par_req = '0;
      assign from_dn = '0;
    end else begin : g_inner
      assign par_a   = rd_a[i-1];
      assign par_req = kid_req[i-1];
      assign from_dn = pass_dn[i-1];
    end

    if (i == LEVELS - 1) begin : g_leaf
      assign kid_a   = '0;
      assign kid_b   = '0;
      assign from_up = '0;
    end else begin : g_mid
      assign kid_a   = rd_a[i+1];
      assign kid_b   = rd_b[i+1];
      assign from_up = pass_up[i+1];
    end

    assign tok_in[i] = (launch.valid && (launch_lvl == LVL_W'(i))) ? launch :
                       (from_up.valid ? from_up : from_dn);

    hpq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .level   (LVL_W'(i)),
      .mode    (mode),
      .ctl     (ctl),
      .tok_in  (tok_in[i]),
      .par_a   (par_a),
      .par_req (par_req),
      .kid_a   (kid_a),
      .kid_b   (kid_b),
      .ram     (ram_q[i]),
      .kid_req (kid_req[i]),
      .pass_up (pass_up[i]),
      .pass_dn (pass_dn[i]),
      .done    (done_v[i])
    );

    hpq_ram #(
      .ADDR_W (LW)
    ) u_ram (
      .clk   (clk),
      .we    (ram_q[i].we),
      .waddr (ram_q[i].waddr[LW-1:0]),
      .wdata (ram_q[i].wdata),
      .rea   (ram_q[i].rea),
      .addra (ram_q[i].addra[LW-1:0]),
      .rda   (rd_a[i]),
      .reb   (ram_q[i].reb),
      .addrb (ram_q[i].addrb[LW-1:0]),
      .rdb   (rd_b[i])
    );
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary heap priority queue testbench
// Drives inserts and removes into the queue with random gaps on both sides.
// A local heap tracks every accepted item, and each result is checked against
// it. The run covers both orderings, the empty and full bounds, equal keys
// and order changes while keys are held.
// ----------------------------------------------------------------------------

module testbench;
  import hpq_pkg::*;

  localparam key_t KEY_MAX = 32'sh7fff_ffff;
  localparam key_t KEY_MIN = 32'sh8000_0000;
  localparam int IDLE_LIMIT = 1000;
  localparam int RES_W = OUT_DATA_W - OUT_PAD_W;

  typedef struct {
    logic op;
    key_t key;
  } heap_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0] total;
    key_t top;
    key_t removed;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // key
  logic [IN_USER_W-1:0] s_tuser = '0;   // operation
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // removed_key, top_key, entry_total, status
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;

  heap_op_t op_backlog[$];
  result_t awaited_results[$];
  key_t heap_slots[0:DEPTH-1];
  int slot_count = 0;
  logic min_on_top = 1'b0;
  int ops_queued = 0;
  int ops_accepted = 0;
  int errors = 0;
  int idle_cycles = 0;
  logic item_taken = 1'b0;
  logic result_taken = 1'b0;
  int send_gap = 0;
  logic send_quiet = 1'b0;
  int sink_hold = 0;
  logic sink_quiet = 1'b0;

  binary_heap_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic outranks(key_t a, key_t b);
    return min_on_top ? (a < b) : (a > b);
  endfunction

  function automatic void swap_slots(int p, int q);
    key_t t;
    t = heap_slots[p];
    heap_slots[p] = heap_slots[q];
    heap_slots[q] = t;
  endfunction

  function automatic result_t apply_heap_op(logic op, key_t key);
    result_t r;
    int pos;
    int best;
    int left;
    logic moving;
    r = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (slot_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = slot_count;
        heap_slots[pos] = key;
        moving = 1'b1;
        while (moving && pos > 0) begin
          if (outranks(heap_slots[pos], heap_slots[(pos - 1) / 2])) begin
            swap_slots(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
          end else begin
            moving = 1'b0;
          end
        end
        slot_count++;
      end
    end else begin
      if (slot_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed = heap_slots[0];
        slot_count--;
        swap_slots(0, slot_count);
        pos = 0;
        moving = 1'b1;
        while (moving) begin
          best = pos;
          left = 2 * pos + 1;
          if (left < slot_count && outranks(heap_slots[left], heap_slots[best])) begin
            best = left;
          end
          if (left + 1 < slot_count && outranks(heap_slots[left + 1], heap_slots[best])) begin
            best = left + 1;
          end
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    if (slot_count > 0) begin
      r.top = heap_slots[0];
    end
    r.total = TOTAL_W'(slot_count);
    return r;
  endfunction

  // Check results and track accepted items at the rising edge.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    got = result_t'(m_tdata[RES_W-1:0]);
    if (rst) begin
      slot_count = 0;
      min_on_top <= 1'b0;
      item_taken <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      item_taken <= s_tvalid && s_tready;
      result_taken <= m_tvalid && m_tready;
      if (cfg_write) begin
        min_on_top <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: removed=%0d top=%0d total=%0d status=%0d",
                     got.removed, got.top, got.total, got.status);
          end
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata !== {{OUT_PAD_W{1'b0}}, want}) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected removed=%0d top=%0d total=%0d status=%0d",
                       want.removed, want.top, want.total, want.status);
              $display("  got removed=%0d top=%0d total=%0d status=%0d pad=%b",
                       got.removed, got.top, got.total, got.status,
                       m_tdata[OUT_DATA_W-1:RES_W]);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(apply_heap_op(s_tuser[0], key_t'(s_tdata)));
        ops_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    heap_op_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (op_backlog.size() > 0) begin
        item = op_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= item.key;
        s_tuser <= item.op;
        if ($urandom_range(0, 39) == 0) begin
          send_quiet = !send_quiet;
        end
        send_gap = send_quiet ? 0 : $urandom_range(0, 6);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (result_taken) begin
        if ($urandom_range(0, 39) == 0) begin
          sink_quiet = !sink_quiet;
        end
        sink_hold = sink_quiet ? 0 : $urandom_range(0, 6);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic void queue_op(logic op, key_t key);
    heap_op_t item;
    item.op = op;
    item.key = key;
    op_backlog.push_back(item);
    ops_queued++;
  endfunction

  function automatic key_t pick_key();
    key_t k;
    k = key_t'($urandom);
    case ($urandom_range(0, 9))
      6, 7: k = key_t'($urandom_range(0, 16)) - 32'sd8;
      8: begin
        case ($urandom_range(0, 3))
          0: k = KEY_MAX;
          1: k = KEY_MIN;
          2: k = '0;
          default: k = -32'sd1;
        endcase
      end
      9: k = $urandom_range(0, 1) ? KEY_MAX - key_t'($urandom_range(0, 3))
                                  : KEY_MIN + key_t'($urandom_range(0, 3));
      default: ;
    endcase
    return k;
  endfunction

  function automatic void queue_directed();
    queue_op(OP_REMOVE, pick_key());
    queue_op(OP_INSERT, KEY_MAX);
    queue_op(OP_INSERT, KEY_MIN);
    queue_op(OP_INSERT, '0);
    queue_op(OP_INSERT, -32'sd1);
    queue_op(OP_INSERT, 32'sd7);
    queue_op(OP_INSERT, 32'sd7);
    repeat (6) queue_op(OP_REMOVE, pick_key());
  endfunction

  function automatic void queue_random(int count, int insert_pct);
    repeat (count) begin
      queue_op(($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE, pick_key());
    end
  endfunction

  task automatic await_idle();
    while (ops_accepted != ops_queued || awaited_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_order(logic m);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int insert_pcts[7];
    insert_pcts = '{30, 55, 75, 90, 50, 20, 60};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_order(1'b0);
    queue_directed();
    await_idle();
    write_order(1'b1);
    queue_directed();
    await_idle();

    // Fill to the bound, then push against it.
    write_order(1'b0);
    repeat (DEPTH + 3) queue_op(OP_INSERT, pick_key());
    await_idle();

    // The order flips between phases while keys are still held.
    for (int p = 0; p < 7; p++) begin
      write_order(p % 2 == 0);
      queue_random(200, insert_pcts[p]);
      await_idle();
    end

    write_order(1'($urandom_range(0, 1)));
    repeat (slot_count + 2) queue_op(OP_REMOVE, pick_key());
    await_idle();

    repeat (40) @(negedge clk);
    errors += awaited_results.size();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
